FILE: design/kth_smallest_stream_select_assert.svh
// assertion macros for the checker of the selection block
`ifndef KTH_SMALLEST_STREAM_SELECT_ASSERT_SVH
`define KTH_SMALLEST_STREAM_SELECT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define KSS_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("kss check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define KSS_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("kss check failed");

`endif

FILE: design/kss_pkg.sv
package kss_pkg;

    localparam int KW = 7;   // width of k and of the fill count
    localparam int PW = 8;   // heap position width, holds child indices of k up to 127
    localparam int DW = 32;

    typedef logic signed [DW-1:0] t_data;

    typedef struct packed {
        t_data kth;
        logic  ready_res;
    } t_result;

endpackage

FILE: design/kss_ram.sv
module kss_ram #(
    parameter int W = 32,
    parameter int D = 64,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/kss_ctrl.sv
module kss_ctrl #(
    parameter int AW = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  kss_pkg::t_data         i_value,
    input  logic                   i_restart,
    input  logic [kss_pkg::KW-1:0] i_k,
    output logic                   o_res_valid,
    output kss_pkg::t_result       o_res,
    input  logic                   i_res_ready,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output kss_pkg::t_data         o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  kss_pkg::t_data         i_mem_rdata
);

    import kss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DN_L,
        S_DN_R,
        S_PUT,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [KW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_pos, n_pos;
    t_data         r_val, n_val;
    t_data         r_lval, n_lval;
    t_data         r_root, n_root;
    logic          r_rdy, n_rdy;

    logic          we;
    logic [PW-1:0] wpos;
    t_data         wdata;
    logic [PW-1:0] rpos;

    always_comb begin
        logic [KW-1:0] f0;
        logic [KW-1:0] f1;
        logic [PW-1:0] kx;
        logic [PW-1:0] lc;
        logic [PW-1:0] rc;
        logic [PW-1:0] par;
        logic [PW-1:0] bpos;
        logic [PW-1:0] nlc;
        t_data         bv;
        logic          moved;

        n_state = r_state;
        n_fill  = r_fill;
        n_pos   = r_pos;
        n_val   = r_val;
        n_lval  = r_lval;
        n_rdy   = r_rdy;
        we      = 1'b0;
        wpos    = r_pos;
        wdata   = r_val;
        rpos    = '0;

        f0    = i_restart ? '0 : r_fill;
        f1    = (f0 > i_k) ? i_k : f0;
        kx    = PW'(i_k);
        lc    = (r_pos << 1) + PW'(1);
        rc    = (r_pos << 1) + PW'(2);
        par   = (r_pos - PW'(1)) >> 1;
        bpos  = r_pos;
        bv    = r_val;
        moved = 1'b0;
        nlc   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val = i_value;
                    if (f1 < i_k) begin
                        // still filling: append at the end and sift up
                        n_fill = f1 + KW'(1);
                        n_rdy  = ((f1 + KW'(1)) >= i_k);
                        n_pos  = PW'(f1);
                        if (f1 == '0) begin
                            n_state = S_PUT;
                        end else begin
                            rpos    = (PW'(f1) - PW'(1)) >> 1;
                            n_state = S_UP;
                        end
                    end else begin
                        n_fill = f1;
                        n_rdy  = 1'b1;
                        n_pos  = '0;
                        if (i_value < r_root) begin
                            // replace the root and sift down
                            if (i_k > KW'(1)) begin
                                rpos    = PW'(1);
                                n_state = S_DN_L;
                            end else begin
                                n_state = S_PUT;
                            end
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_UP: begin
                // read data is the parent of r_pos
                if (i_mem_rdata < r_val) begin
                    we    = 1'b1;
                    wpos  = r_pos;
                    wdata = i_mem_rdata;
                    n_pos = par;
                    if (par == '0) begin
                        n_state = S_PUT;
                    end else begin
                        rpos = (par - PW'(1)) >> 1;
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DN_L: begin
                rpos    = rc;
                n_lval  = i_mem_rdata;
                n_state = S_DN_R;
            end
            S_DN_R: begin
                // larger child, left wins a tie
                if (r_val < r_lval) begin
                    bpos  = lc;
                    bv    = r_lval;
                    moved = 1'b1;
                end
                if ((rc < kx) && (bv < i_mem_rdata)) begin
                    bpos  = rc;
                    bv    = i_mem_rdata;
                    moved = 1'b1;
                end
                nlc = (bpos << 1) + PW'(1);
                if (moved) begin
                    we    = 1'b1;
                    wpos  = r_pos;
                    wdata = bv;
                    n_pos = bpos;
                    if (nlc < kx) begin
                        rpos    = nlc;
                        n_state = S_DN_L;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                we      = 1'b1;
                wpos    = r_pos;
                wdata   = r_val;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // keep a copy of entry 0 so the root needs no memory read
        n_root = (we && (wpos == '0)) ? wdata : r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_lval <= n_lval;
        r_root <= n_root;
        r_rdy  <= n_rdy;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.kth       = r_root;
    assign o_res.ready_res = r_rdy;
    assign o_mem_we        = we;
    assign o_mem_waddr     = AW'(wpos);
    assign o_mem_wdata     = wdata;
    assign o_mem_raddr     = AW'(rpos);

endmodule

FILE: design/kth_smallest_stream_select.sv
// Streaming k-th smallest selector. Signed 32-bit values arrive one beat at a time and the
// k smallest of the current set are kept in a max-heap held in a single-port-read RAM of
// MAX_K entries; each input beat returns the heap root (the k-th smallest so far, or the
// largest so far while the set is still short of k values) and ready_res once k values
// have arrived. restart starts a new set. k is written through the config channel
// (0 acts as 1, above MAX_K acts as MAX_K) and should only change between items.
// Order of work: one item at a time, from the edge that takes a beat to the edge that
// presents its result. A value that leaves the heap untouched goes straight to its result;
// the first value of a set, or a replacement with k = 1, first writes its entry; any other
// insert while filling reads the parent once per heap level climbed, moves it down, then
// writes the value; a replacement of the root reads the left and then the right child of
// each level descended through the one RAM read port, moves the larger one up, and writes
// the value where it stops. The worst case is a replacement at k = 64 that sinks to the
// bottom of the heap. The next beat is taken the cycle after the result is handed on.
// A result waiting in the output register does not stop the next beat from being taken,
// but the block holds its next result until that register is free.
module kth_smallest_stream_select #(
    parameter int MAX_K = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [kss_pkg::KW-1:0] i_cfg_k_in_use,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [31:0]     i_value,
    input  logic                   i_restart,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [31:0]     o_kth_smallest,
    output logic                   o_ready_res
);

    import kss_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    logic [KW-1:0] r_k_cfg;
    logic [KW-1:0] k_eff;
    logic          r_out_valid;
    t_result       r_out;

    logic          res_valid;
    t_result       res;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_data         mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_data         mem_rdata;

    always_comb begin
        k_eff = (r_k_cfg == '0) ? KW'(1) : r_k_cfg;
        if (int'(k_eff) > MAX_K) begin
            k_eff = KW'(MAX_K);
        end
    end

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_cfg     <= KW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_k_cfg <= i_cfg_k_in_use;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    kss_ctrl #(
        .AW(AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_restart   (i_restart),
        .i_k         (k_eff),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    kss_ram #(
        .W (DW),
        .D (MAX_K),
        .AW(AW)
    ) u_heap (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_kth_smallest = r_out.kth;
    assign o_ready_res    = r_out.ready_res;

endmodule

FILE: design/kss_chk.sv
`include "kth_smallest_stream_select_assert.svh"

module kss_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [6:0]         i_cfg_k_in_use,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic signed [31:0] i_value,
    input logic               i_restart,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_kth_smallest,
    input logic               o_ready_res
);

    // the sequencer is busy in the cycle after it takes a beat
    `KSS_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // a fresh result only appears as the sequencer leaves its busy period
    `KSS_ASSERT_IMP(a_result_after_work, $rose(o_out_valid), !$past(o_in_ready))

    // a stalled result beat holds its payload
    `KSS_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kth_smallest) && $stable(o_ready_res))

endmodule

bind kth_smallest_stream_select kss_chk u_kss_chk (.*);

FILE: sim/kss_checker.sv
module kss_checker #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [kss_pkg::KW-1:0] i_cfg_k,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  kss_pkg::t_data         i_value,
    input  logic                   i_restart,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  kss_pkg::t_data         i_kth,
    input  logic                   i_ready_res,
    input  logic                   i_drain_done,
    output int                     o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import kss_pkg::*;

    localparam int PRINT_CAP = 200;

    t_data         heap_vals [HEAP_DEPTH];
    int            fill_level;
    logic [KW-1:0] k_setting;
    t_result       roots_due [$];
    int            fail_total;
    int            result_beat;
    bit            drain_seen;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what);
        // keep the log readable when the block is badly broken
        if (fail_total < PRINT_CAP)
            $display("%0t mismatch: %s", $realtime, what);
        fail_total++;
    endtask

    function automatic int effective_k();
        if (k_setting < 1)
            return 1;
        if (k_setting > HEAP_DEPTH)
            return HEAP_DEPTH;
        return int'(k_setting);
    endfunction

    task automatic swap_slots(input int a, input int b);
        t_data tmp;
        tmp          = heap_vals[a];
        heap_vals[a] = heap_vals[b];
        heap_vals[b] = tmp;
    endtask

    // keeps the k smallest of the set in a max-heap, root is the k-th smallest
    task automatic select_step(input t_data v, input logic rs, output t_result res);
        int k;
        int pos;
        int par;
        int best;
        int lc;
        int rc;
        k = effective_k();
        if (rs)
            fill_level = 0;
        if (fill_level > k)
            fill_level = k;
        if (fill_level < k) begin
            heap_vals[fill_level] = v;
            pos = fill_level;
            while (pos > 0) begin
                par = (pos - 1) / 2;
                if (!(heap_vals[par] < heap_vals[pos]))
                    break;
                swap_slots(par, pos);
                pos = par;
            end
            fill_level++;
        end else if (v < heap_vals[0]) begin
            heap_vals[0] = v;
            pos = 0;
            forever begin
                best = pos;
                lc   = 2 * pos + 1;
                rc   = lc + 1;
                // strict compares, so the left child wins a tie
                if (lc < k && heap_vals[best] < heap_vals[lc])
                    best = lc;
                if (rc < k && heap_vals[best] < heap_vals[rc])
                    best = rc;
                if (best == pos)
                    break;
                swap_slots(best, pos);
                pos = best;
            end
        end
        res.kth       = heap_vals[0];
        res.ready_res = (fill_level >= k);
    endtask

    initial begin
        fail_total  = 0;
        result_beat = 0;
        drain_seen  = 0;
        fill_level  = 0;
        k_setting   = 1;
    end

    always @(posedge i_clk) begin : watch
        t_result due;
        t_result fresh;
        if (!i_rst_n) begin
            fill_level = 0;
            k_setting  = 1;
            roots_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                k_setting = i_cfg_k;
            // results first, an item taken this edge cannot answer on the same edge
            if (i_out_valid && i_out_ready) begin
                if (roots_due.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing pending",
                                              result_beat));
                end else begin
                    due = roots_due.pop_front();
                    if (i_kth !== due.kth)
                        report_mismatch($sformatf("beat %0d kth_smallest %0d, want %0d",
                                                  result_beat, i_kth, due.kth));
                    if (i_ready_res !== due.ready_res)
                        report_mismatch($sformatf("beat %0d ready_res %b, want %b",
                                                  result_beat, i_ready_res, due.ready_res));
                end
                result_beat++;
            end
            if (i_in_valid && i_in_ready) begin
                select_step(i_value, i_restart, fresh);
                roots_due.push_back(fresh);
            end
            if (i_drain_done && !drain_seen) begin
                drain_seen = 1;
                if (roots_due.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived", roots_due.size()));
            end
        end
    end

endmodule

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kss_pkg::*;

    localparam int    ITEM_TARGET = 1750;
    localparam int    HOLD_AFTER  = 300;
    localparam int    HOLD_CYCLES = 500;
    localparam t_data VAL_MIN     = 32'sh8000_0000;
    localparam t_data VAL_MAX     = 32'sh7fff_ffff;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [KW-1:0] i_cfg_k_in_use;
    logic          i_in_valid;
    logic          o_in_ready;
    t_data         i_value;
    logic          i_restart;
    logic          o_out_valid;
    logic          i_out_ready;
    t_data         o_kth_smallest;
    logic          o_ready_res;
    logic          drain_done;
    int            fail_count;

    int            beats_in;
    int            beats_out;
    t_data         trend_val;

    kth_smallest_stream_select u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_k_in_use (i_cfg_k_in_use),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kth_smallest (o_kth_smallest),
        .o_ready_res    (o_ready_res)
    );

    kss_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_k      (i_cfg_k_in_use),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_value      (i_value),
        .i_restart    (i_restart),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_kth        (o_kth_smallest),
        .i_ready_res  (o_ready_res),
        .i_drain_done (drain_done),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            beats_out <= beats_out + 1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_k(input logic [KW-1:0] k);
        if (k < 1)
            return 1;
        if (k > 64)
            return 64;
        return int'(k);
    endfunction

    task automatic send_item(input t_data v, input logic rs, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_restart  <= rs;
        do @(posedge i_clk); while (!o_in_ready);
        beats_in++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (beats_out != beats_in)
            @(posedge i_clk);
    endtask

    task automatic write_k(input logic [KW-1:0] k);
        wait_idle();
        i_cfg_valid    <= 1'b1;
        i_cfg_k_in_use <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic make_value(input int vmode, output t_data v);
        case (vmode)
            1: v = t_data'(int'($urandom_range(0, 8)) - 4);
            2: begin
                // falling run, once the heap is full every value pushes out the root
                trend_val = trend_val - t_data'($urandom_range(1, 5000));
                v = trend_val;
            end
            3: begin
                trend_val = trend_val + t_data'($urandom_range(1, 5000));
                v = trend_val;
            end
            4: v = $urandom_range(0, 1) ? VAL_MIN + t_data'($urandom_range(0, 3))
                                        : VAL_MAX - t_data'($urandom_range(0, 3));
            default: v = t_data'($urandom);
        endcase
    endtask

    // receiver side, with one long hold-off so the block backs up
    initial begin : result_side
        int  stall;
        int  calm_left;
        bit  held;
        stall       = 0;
        calm_left   = 0;
        held        = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && beats_out >= HOLD_AFTER) begin
                held = 1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 3)
                    calm_left = $urandom_range(50, 200);
                else
                    stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        logic [KW-1:0] k_pick;
        int            keff;
        int            phase_no;
        int            phase_len;
        int            set_left;
        int            vmode;
        bit            calm;
        logic          rs_next;
        t_data         v;

        beats_in       = 0;
        trend_val      = '0;
        drain_done     <= 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_k_in_use <= '0;
        i_in_valid     <= 1'b0;
        i_value        <= '0;
        i_restart      <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // k = 1 from reset, no restart yet: the stream since reset is one set
        send_item(VAL_MAX, 1'b0, 0);
        send_item(VAL_MIN, 1'b0, 0);
        send_item(0, 1'b0, 0);
        send_item(-1, 1'b0, 0);
        send_item(VAL_MAX, 1'b0, 0);

        // ties at the root and both extremes
        write_k(3);
        send_item(7, 1'b1, 0);
        send_item(7, 1'b0, 0);
        send_item(7, 1'b0, 0);
        send_item(5, 1'b0, 0);
        send_item(9, 1'b0, 0);
        send_item(VAL_MIN, 1'b0, 0);
        send_item(VAL_MAX, 1'b0, 0);

        // k of zero acts as one, above the depth acts as the depth
        write_k(0);
        send_item(VAL_MAX, 1'b1, 0);
        send_item(VAL_MAX, 1'b0, 0);
        send_item(VAL_MIN, 1'b0, 0);
        write_k(127);
        send_item(VAL_MIN, 1'b1, 0);
        send_item(-1, 1'b0, 0);

        // full heap, then k lowered and raised inside the same set
        write_k(5);
        send_item(4, 1'b1, 0);
        send_item(3, 1'b0, 0);
        send_item(2, 1'b0, 0);
        send_item(1, 1'b0, 0);
        send_item(0, 1'b0, 0);
        write_k(2);
        send_item(10, 1'b0, 0);
        send_item(-5, 1'b0, 0);
        write_k(6);
        send_item(100, 1'b0, 0);
        send_item(-100, 1'b0, 0);

        keff     = 6;
        set_left = 0;
        vmode    = 0;
        phase_no = 0;
        while (beats_in < ITEM_TARGET) begin
            if (phase_no == 0)
                k_pick = 64;
            else if (phase_no == 1)
                k_pick = 1;
            else begin
                case ($urandom_range(0, 9))
                    0:       k_pick = 1;
                    1:       k_pick = 64;
                    2:       k_pick = 0;
                    3:       k_pick = 127;
                    4:       k_pick = $urandom_range(65, 126);
                    default: k_pick = $urandom_range(2, 16);
                endcase
            end
            write_k(k_pick);
            keff = clamp_k(k_pick);
            // most phases start a new set, the rest carry the old one across the change
            if ($urandom_range(0, 3) != 0)
                set_left = 0;
            phase_len = $urandom_range(40, 160);
            calm      = ($urandom_range(0, 3) == 0);
            rs_next   = 1'b0;
            repeat (phase_len) begin
                if (set_left <= 0) begin
                    rs_next   = 1'b1;
                    vmode     = $urandom_range(0, 4);
                    trend_val = t_data'($urandom);
                    if ($urandom_range(0, 4) == 0)
                        set_left = $urandom_range(1, keff);
                    else
                        set_left = keff + $urandom_range(0, 2 * keff + 20);
                end
                make_value(vmode, v);
                send_item(v, rs_next, calm);
                rs_next = 1'b0;
                set_left--;
            end
            phase_no++;
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/kss_pkg.sv
design/kss_ram.sv
design/kss_ctrl.sv
design/kth_smallest_stream_select.sv
design/kss_chk.sv
sim/kss_checker.sv
sim/testbench.sv
